@@ hdl/rxdg_pkg.sv @@
// ----------------------------------------------------------------------------
// rxdg_pkg
// Shared types, codes and constants of the radial exponential descriptor
// gradient accumulator.
// ----------------------------------------------------------------------------
package rxdg_pkg;

  // Table geometry: row per type, one entry per exponent term.
  localparam int unsigned NUM_TYPES = 8;
  localparam int unsigned MAX_ALPHA = 16;
  localparam int unsigned TYPE_W    = $clog2(NUM_TYPES);
  localparam int unsigned ALPHA_W   = $clog2(MAX_ALPHA);
  localparam int unsigned IDX_W     = TYPE_W + ALPHA_W;
  localparam int unsigned TAB_DEPTH = NUM_TYPES * MAX_ALPHA;
  localparam int unsigned CNT_W     = 5;

  // Fixed-point constants of the exponential.
  localparam logic [23:0]        LN2_Q24  = 24'd11629080;
  localparam logic signed [39:0] EXP_HI   = 40'sd360501480;   // 31 * ln2
  localparam logic signed [39:0] EXP_LO   = -40'sd465163200;  // -40 * ln2
  localparam logic signed [39:0] EXP_OFS  = 40'sd465163200;
  localparam logic [16:0]        RECIP_L  = 17'((64'd1 << 40) / 64'd11629080);
  localparam logic [31:0]        ONE_Q30  = 32'h4000_0000;
  localparam logic [63:0]        MAG_LIM  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [3:0]         POLY_N   = 4'd10;
  localparam logic [6:0]         K_BIAS   = 7'd38;

  // floor((2^32 - 1) / n) for the polynomial divisors.
  localparam logic [31:0] RECIP_N [16] = '{
    32'd0, 32'd4294967295, 32'd2147483647, 32'd1431655765,
    32'd1073741823, 32'd858993459, 32'd715827882, 32'd613566756,
    32'd536870911, 32'd477218588, 32'd429496729, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef enum logic [2:0] {
    ACT_LOAD_EXP  = 3'd0,
    ACT_LOAD_WGT  = 3'd1,
    ACT_LOAD_GRAD = 3'd2,
    ACT_NEIGHBOR  = 3'd3,
    ACT_READ      = 3'd4,
    ACT_CLEAR     = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    CT_IDLE, CT_RD_WAIT, CT_T_READ, CT_T_EXP, CT_T_M1,
    CT_T_MA2, CT_T_MA3, CT_T_MA4, CT_T_MW2, CT_T_ACC
  } ctl_state_e;

  typedef enum logic [3:0] {
    EX_IDLE, EX_PROD, EX_RANGE, EX_QEST, EX_REM, EX_FIX,
    EX_PMUL, EX_DMUL, EX_DFIX, EX_SHIFT, EX_DONE
  } exp_state_e;

  typedef enum logic [2:0] {
    MM_IDLE, MM_HI, MM_LO, MM_SUM, MM_DONE
  } mm_state_e;

  // Response of a multi-cycle magnitude unit.
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] mag;
  } mag_rsp_t;

endpackage

@@ hdl/rxdg_ifs.sv @@
// ----------------------------------------------------------------------------
// rxdg channel interfaces
// Valid/ready channels for input beats, result beats and configuration.
// ----------------------------------------------------------------------------
interface rxdg_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [2:0]         type_index;
  logic [3:0]         alpha_index;
  logic signed [31:0] value;
  modport source (output valid, action, type_index, alpha_index, value, input ready);
  modport sink   (input valid, action, type_index, alpha_index, value, output ready);
endinterface

interface rxdg_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] exponent_gradient;
  logic signed [63:0] weight_gradient;
  logic               saturated;
  modport source (output valid, exponent_gradient, weight_gradient, saturated,
                  input ready);
  modport sink   (input valid, exponent_gradient, weight_gradient, saturated,
                  output ready);
endinterface

interface rxdg_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] alpha_count;
  modport source (output valid, alpha_count, input ready);
  modport sink   (input valid, alpha_count, output ready);
endinterface

@@ hdl/rxdg_ram.sv @@
// ----------------------------------------------------------------------------
// rxdg_ram
// Generic single-write, single-read RAM; read data is registered and held
// until the next read.
// ----------------------------------------------------------------------------
module rxdg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rxdg_exp.sv @@
// ----------------------------------------------------------------------------
// rxdg_exp
// Multi-cycle exponential of a*d: range reduction by ln2, a ten-step
// polynomial in Q2.30 and a final saturating scale by a power of two.
// ----------------------------------------------------------------------------
module rxdg_exp import rxdg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] d_i,
  output mag_rsp_t           rsp_o
);

  exp_state_e         state_q, state_d;
  logic signed [31:0] a_q, d_q;
  logic signed [63:0] ad_q;
  logic [29:0]        y_q;
  logic [46:0]        qm_q;
  logic [6:0]         k_q;
  logic [24:0]        rem_q;
  logic [29:0]        r30_q;
  logic [31:0]        p_q;
  logic [61:0]        pr_q;
  logic [31:0]        v_q;
  logic [63:0]        vq_q;
  logic [3:0]         n_q;
  logic [63:0]        e_q;
  logic               sat_q;

  logic signed [39:0] x;
  logic               x_hi, x_lo;
  logic [30:0]        ql;
  logic [24:0]        rem_fix;
  logic               rem_ge;
  logic [31:0]        qd;
  logic [35:0]        qn, chk;
  logic [31:0]        p_next;
  logic [5:0]         lsh, rsh;
  logic [95:0]        wide;
  logic [63:0]        narrow;

  // Reduced argument and its range tests.
  assign x    = ad_q[63:24];
  assign x_hi = (x >= EXP_HI);
  assign x_lo = (x < EXP_LO);

  // Remainder of the reciprocal estimate and its one-step correction.
  assign ql      = 31'(qm_q[46:40]) * 31'(LN2_Q24);
  assign rem_ge  = (rem_q >= 25'(LN2_Q24));
  assign rem_fix = rem_ge ? (rem_q - 25'(LN2_Q24)) : rem_q;

  // Polynomial step: quotient by n with one correction.
  assign qd     = vq_q[63:32];
  assign qn     = {4'b0, qd} * {32'b0, n_q};
  assign chk    = {4'b0, v_q} - qn;
  assign p_next = ONE_Q30 + qd + 32'(chk >= {32'b0, n_q});

  // Final scale by 2^(k-38).
  assign lsh    = 6'(k_q - K_BIAS);
  assign rsh    = 6'(K_BIAS - k_q);
  assign wide   = {64'b0, p_q} << lsh;
  assign narrow = {32'b0, p_q} >> rsh;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EX_IDLE:  if (start_i) begin state_d = EX_PROD; end
      EX_PROD:  state_d = EX_RANGE;
      EX_RANGE: state_d = (x_hi || x_lo) ? EX_DONE : EX_QEST;
      EX_QEST:  state_d = EX_REM;
      EX_REM:   state_d = EX_FIX;
      EX_FIX:   state_d = EX_PMUL;
      EX_PMUL:  state_d = EX_DMUL;
      EX_DMUL:  state_d = EX_DFIX;
      EX_DFIX:  state_d = (n_q == 4'd1) ? EX_SHIFT : EX_PMUL;
      EX_SHIFT: state_d = EX_DONE;
      EX_DONE:  state_d = EX_IDLE;
      default:  state_d = EX_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp_o.done = (state_q == EX_DONE);
    rsp_o.sat  = sat_q;
    rsp_o.mag  = e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EX_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      EX_IDLE: begin
        a_q <= a_i;
        d_q <= d_i;
      end
      EX_PROD: ad_q <= a_q * d_q;
      EX_RANGE: begin
        y_q   <= 30'(x + EXP_OFS);
        sat_q <= x_hi;
        e_q   <= x_hi ? MAG_LIM : 64'd0;
      end
      EX_QEST: qm_q <= {17'b0, y_q} * {30'b0, RECIP_L};
      EX_REM: begin
        k_q   <= qm_q[46:40];
        rem_q <= 25'(31'(y_q) - ql);
      end
      EX_FIX: begin
        k_q   <= k_q + 7'(rem_ge);
        r30_q <= {rem_fix[23:0], 6'b0};
        p_q   <= ONE_Q30;
        n_q   <= POLY_N;
      end
      EX_PMUL: pr_q <= {30'b0, p_q} * {32'b0, r30_q};
      EX_DMUL: begin
        v_q  <= pr_q[61:30];
        vq_q <= {32'b0, pr_q[61:30]} * {32'b0, RECIP_N[n_q]};
      end
      EX_DFIX: begin
        p_q <= p_next;
        n_q <= n_q - 4'd1;
      end
      EX_SHIFT: begin
        if (k_q >= K_BIAS) begin
          sat_q <= |wide[95:63];
          e_q   <= (|wide[95:63]) ? MAG_LIM : wide[63:0];
        end else begin
          sat_q <= 1'b0;
          e_q   <= narrow;
        end
      end
      EX_DONE: ;
      default: ;
    endcase
  end

endmodule

@@ hdl/rxdg_mulmag.sv @@
// ----------------------------------------------------------------------------
// rxdg_mulmag
// Saturating magnitude product of a Q32.32 value and a Q8.24 magnitude,
// built from two passes through one 32x32 multiplier.
// ----------------------------------------------------------------------------
module rxdg_mulmag import rxdg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] m_i,
  input  logic [31:0] vm_i,
  output mag_rsp_t    rsp_o
);

  mm_state_e   state_q, state_d;
  logic [63:0] m_q;
  logic [31:0] vm_q;
  logic [63:0] hv_q, lv_q, res_q;
  logic        sat_q;

  logic [31:0] mul_op;
  logic [63:0] prod;
  logic        hv_ovf;
  logic [63:0] sum;

  // Shared multiplier: high half first, then low half.
  assign mul_op = (state_q == MM_HI) ? m_q[63:32] : m_q[31:0];
  assign prod   = {32'b0, mul_op} * {32'b0, vm_q};

  // Recombine the partial products, dropping 24 fraction bits.
  assign hv_ovf = |hv_q[63:55];
  assign sum    = {hv_q[55:0], 8'b0} + {24'b0, lv_q[63:24]};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MM_IDLE: if (start_i) begin state_d = MM_HI; end
      MM_HI:   state_d = MM_LO;
      MM_LO:   state_d = MM_SUM;
      MM_SUM:  state_d = MM_DONE;
      MM_DONE: state_d = MM_IDLE;
      default: state_d = MM_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp_o.done = (state_q == MM_DONE);
    rsp_o.sat  = sat_q;
    rsp_o.mag  = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      MM_IDLE: begin
        m_q  <= m_i;
        vm_q <= vm_i;
      end
      MM_HI: hv_q <= prod;
      MM_LO: lv_q <= prod;
      MM_SUM: begin
        sat_q <= hv_ovf | sum[63];
        res_q <= (hv_ovf | sum[63]) ? MAG_LIM : sum;
      end
      MM_DONE: ;
      default: ;
    endcase
  end

endmodule

@@ hdl/radial_exp_descriptor_gradient.sv @@
// ----------------------------------------------------------------------------
// radial_exp_descriptor_gradient
// Accumulates exponent and weight gradients of exponential radial
// descriptors in table memories, one exponent term at a time.
// ----------------------------------------------------------------------------
// Loads, clears and unused actions are taken without leaving the idle state;
// a read waits for room in the output register and gives one result beat.
// A neighbor beat works through min(alpha_count, 16) terms, each read from
// the tables, passed through the exponential unit and five saturating
// multiplies, then written back to the accumulator memory; the exponential
// unit runs a ten-step polynomial. Clear empties the accumulators at once
// through per-entry valid bits. No new beat is taken while a neighbor or
// read is in progress; a finished result may wait in the output register
// while later beats are accepted.
// ----------------------------------------------------------------------------
module radial_exp_descriptor_gradient import rxdg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rxdg_in_if.sink    in_i,
  rxdg_out_if.source out_o,
  rxdg_cfg_if.sink   cfg_i
);

  ctl_state_e         state_q, state_d;
  logic [CNT_W-1:0]   alpha_count_q;
  logic [TYPE_W-1:0]  type_q;
  logic signed [31:0] d_q;
  logic [CNT_W-1:0]   n_q, term_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [TAB_DEPTH-1:0] valid_q;
  logic               flag_q;
  logic               issued_q;
  logic [63:0]        e_q, ta_q, tw_q;
  logic               out_valid_q, out_sat_q;
  logic [63:0]        out_a_q, out_w_q;

  logic               in_acc;
  action_e            act;
  logic [IDX_W-1:0]   in_idx, term_idx, look_idx;
  logic [CNT_W-1:0]   n_lim;
  logic               last_term;

  logic               tab_re, acc_re, acc_we, exp_start, mm_start;
  logic [IDX_W-1:0]   acc_raddr;
  logic [63:0]        mm_m;
  logic [31:0]        mm_v;

  logic [31:0]        exp_rd, wgt_rd, grad_rd;
  logic [127:0]       acc_rd;
  mag_rsp_t           exp_rsp, mm_rsp;

  logic [31:0]        dm, wm, gm;
  logic               neg_a, neg_w;
  logic [63:0]        acc_a, acc_w, term_a, term_w;
  logic [64:0]        sum_a, sum_w;
  logic               ovf_a, ovf_w;
  logic [63:0]        new_a, new_w;
  logic               out_load;

  // Beat decode.
  assign in_acc   = in_i.valid && in_i.ready;
  assign act      = action_e'(in_i.action);
  assign in_idx   = {in_i.type_index, in_i.alpha_index};
  assign term_idx = {type_q, term_q[ALPHA_W-1:0]};
  assign look_idx = (state_q == CT_RD_WAIT) ? rd_idx_q : term_idx;
  assign n_lim    = (alpha_count_q > CNT_W'(MAX_ALPHA)) ? CNT_W'(MAX_ALPHA) : alpha_count_q;
  assign last_term = ((term_q + CNT_W'(1)) == n_q);

  // Magnitudes and signs of the term operands.
  assign dm    = d_q[31] ? 32'(-d_q) : d_q;
  assign wm    = wgt_rd[31] ? 32'(-wgt_rd) : wgt_rd;
  assign gm    = grad_rd[31] ? 32'(-grad_rd) : grad_rd;
  assign neg_a = wgt_rd[31] ^ grad_rd[31];
  assign neg_w = d_q[31] ^ grad_rd[31];

  // Saturating accumulation; an entry not written since clear reads as zero.
  assign acc_a  = valid_q[look_idx] ? acc_rd[127:64] : 64'd0;
  assign acc_w  = valid_q[look_idx] ? acc_rd[63:0] : 64'd0;
  assign term_a = neg_a ? 64'(-ta_q) : ta_q;
  assign term_w = neg_w ? 64'(-tw_q) : tw_q;
  assign sum_a  = {acc_a[63], acc_a} + {term_a[63], term_a};
  assign sum_w  = {acc_w[63], acc_w} + {term_w[63], term_w};
  assign ovf_a  = sum_a[64] ^ sum_a[63];
  assign ovf_w  = sum_w[64] ^ sum_w[63];
  assign new_a  = ovf_a ? (sum_a[64] ? ~MAG_LIM : MAG_LIM) : sum_a[63:0];
  assign new_w  = ovf_w ? (sum_w[64] ? ~MAG_LIM : MAG_LIM) : sum_w[63:0];

  assign out_load = (state_q == CT_RD_WAIT) && (!out_valid_q || out_o.ready);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CT_IDLE: begin
        if (in_acc && act == ACT_READ) begin
          state_d = CT_RD_WAIT;
        end else if (in_acc && act == ACT_NEIGHBOR && n_lim != '0) begin
          state_d = CT_T_READ;
        end
      end
      CT_RD_WAIT: if (out_load) begin state_d = CT_IDLE; end
      CT_T_READ:  state_d = CT_T_EXP;
      CT_T_EXP:   if (exp_rsp.done) begin state_d = CT_T_M1; end
      CT_T_M1:    if (mm_rsp.done) begin state_d = CT_T_MA2; end
      CT_T_MA2:   if (mm_rsp.done) begin state_d = CT_T_MA3; end
      CT_T_MA3:   if (mm_rsp.done) begin state_d = CT_T_MA4; end
      CT_T_MA4:   if (mm_rsp.done) begin state_d = CT_T_MW2; end
      CT_T_MW2:   if (mm_rsp.done) begin state_d = CT_T_ACC; end
      CT_T_ACC:   state_d = last_term ? CT_IDLE : CT_T_READ;
      default:    state_d = CT_IDLE;
    endcase
  end

  // Control strobes and operand selection.
  always_comb begin
    tab_re    = (state_q == CT_T_READ);
    acc_re    = tab_re || (in_acc && act == ACT_READ);
    acc_raddr = tab_re ? term_idx : in_idx;
    acc_we    = (state_q == CT_T_ACC);
    exp_start = (state_q == CT_T_EXP) && !issued_q;
    mm_start  = 1'b0;
    mm_m      = ta_q;
    mm_v      = dm;
    unique case (state_q)
      CT_T_M1: begin
        mm_start = !issued_q;
        mm_m     = e_q;
      end
      CT_T_MA2: mm_start = !issued_q;
      CT_T_MA3: begin
        mm_start = !issued_q;
        mm_v     = wm;
      end
      CT_T_MA4: begin
        mm_start = !issued_q;
        mm_v     = gm;
      end
      CT_T_MW2: begin
        mm_start = !issued_q;
        mm_m     = tw_q;
        mm_v     = gm;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= CT_IDLE;
      alpha_count_q <= CNT_W'(1);
      valid_q       <= '0;
      flag_q        <= 1'b0;
      issued_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        alpha_count_q <= cfg_i.alpha_count;
      end
      // Unit start/finish tracking.
      if (exp_start || mm_start) begin
        issued_q <= 1'b1;
      end else if (exp_rsp.done || mm_rsp.done) begin
        issued_q <= 1'b0;
      end
      // Saturation flag and accumulator valid bits.
      if (in_acc && act == ACT_CLEAR) begin
        flag_q  <= 1'b0;
        valid_q <= '0;
      end else begin
        if ((exp_rsp.done && exp_rsp.sat) || (mm_rsp.done && mm_rsp.sat) ||
            (acc_we && (ovf_a || ovf_w))) begin
          flag_q <= 1'b1;
        end
        if (acc_we) begin
          valid_q[term_idx] <= 1'b1;
        end
      end
      // Result register.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Term payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      type_q   <= in_i.type_index;
      d_q      <= in_i.value;
      n_q      <= n_lim;
      rd_idx_q <= in_idx;
      term_q   <= '0;
    end
    if (state_q == CT_T_ACC) begin
      term_q <= term_q + CNT_W'(1);
    end
    if (state_q == CT_T_EXP && exp_rsp.done) begin
      e_q <= exp_rsp.mag;
    end
    if (mm_rsp.done) begin
      unique case (state_q)
        CT_T_M1: begin
          ta_q <= mm_rsp.mag;
          tw_q <= mm_rsp.mag;
        end
        CT_T_MW2: tw_q <= mm_rsp.mag;
        default:  ta_q <= mm_rsp.mag;
      endcase
    end
    if (out_load) begin
      out_a_q   <= acc_a;
      out_w_q   <= acc_w;
      out_sat_q <= flag_q;
    end
  end

  // Table memories.
  rxdg_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_exp_tab (
    .clk_i   (clk_i),
    .we_i    (in_acc && act == ACT_LOAD_EXP),
    .waddr_i (in_idx),
    .wdata_i (in_i.value),
    .re_i    (tab_re),
    .raddr_i (term_idx),
    .rdata_o (exp_rd)
  );

  rxdg_ram #(.WIDTH(32), .DEPTH(TAB_DEPTH)) u_wgt_tab (
    .clk_i   (clk_i),
    .we_i    (in_acc && act == ACT_LOAD_WGT),
    .waddr_i (in_idx),
    .wdata_i (in_i.value),
    .re_i    (tab_re),
    .raddr_i (term_idx),
    .rdata_o (wgt_rd)
  );

  rxdg_ram #(.WIDTH(32), .DEPTH(MAX_ALPHA)) u_grad_tab (
    .clk_i   (clk_i),
    .we_i    (in_acc && act == ACT_LOAD_GRAD),
    .waddr_i (in_i.alpha_index),
    .wdata_i (in_i.value),
    .re_i    (tab_re),
    .raddr_i (term_q[ALPHA_W-1:0]),
    .rdata_o (grad_rd)
  );

  // Accumulator memory: exponent gradient in the upper half.
  rxdg_ram #(.WIDTH(128), .DEPTH(TAB_DEPTH)) u_acc (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (term_idx),
    .wdata_i ({new_a, new_w}),
    .re_i    (acc_re),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rd)
  );

  // Arithmetic units.
  rxdg_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .a_i     (exp_rd),
    .d_i     (d_q),
    .rsp_o   (exp_rsp)
  );

  rxdg_mulmag u_mulmag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .m_i     (mm_m),
    .vm_i    (mm_v),
    .rsp_o   (mm_rsp)
  );

  // Ports.
  assign in_i.ready              = (state_q == CT_IDLE);
  assign cfg_i.ready             = 1'b1;
  assign out_o.valid             = out_valid_q;
  assign out_o.exponent_gradient = out_a_q;
  assign out_o.weight_gradient   = out_w_q;
  assign out_o.saturated         = out_sat_q;

endmodule

@@ hdl/rxdg_checker.sv @@
// ----------------------------------------------------------------------------
// rxdg_checker
// Port-level checks of the accumulator block, bound to the top level.
// ----------------------------------------------------------------------------
module rxdg_checker import rxdg_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [2:0]  in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_a_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_a_i))
    else $error("stalled result changed");

  // A result register that was empty fills only after a read beat, once the
  // accumulator memory has been read and the result register loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_action_i == ACT_READ, 2))
    else $error("result without a read beat");

  // While a read is fetched, no further beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ACT_READ |=> !in_ready_i)
    else $error("beat accepted during a read");

  // Configuration writes are never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind radial_exp_descriptor_gradient rxdg_checker u_rxdg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_a_i     (out_o.exponent_gradient),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
